// ===== rtl/serial_frame_builder_crc16_stuffing_unit_assert.svh =====
// assertion macros used by the frame builder checker
`ifndef SERIAL_FRAME_BUILDER_CRC16_STUFFING_UNIT_ASSERT_SVH
`define SERIAL_FRAME_BUILDER_CRC16_STUFFING_UNIT_ASSERT_SVH

// antecedent implies consequent in the next cycle, off while in reset
`define SFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle, off while in reset
`define SFB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle, also checked through reset
`define SFB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfb_pkg.sv =====
// types, constants and the crc step shared by the frame builder
`timescale 1ns / 1ps

package sfb_pkg;

    // frame layout
    localparam int SYNC_BYTES = 2;
    localparam int HDR_BYTES  = 8;
    localparam int IDX_W      = $clog2(HDR_BYTES);

    localparam logic [7:0]  SEP_VALUE   = 8'hFF;
    localparam logic [7:0]  CRC_FLAG    = 8'h40;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  STUFF_RESET = 8'h55;

    // input word kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // input tdata layout
    localparam int IN_TDATA_W = 32;
    localparam int FTYPE_LSB  = 0;
    localparam int PLEN_LSB   = 8;
    localparam int CEN_BIT    = 16;
    localparam int PBYTE_LSB  = 17;

    // trailer byte selectors, kept in the index counter during a trailer stuff
    localparam logic [IDX_W-1:0] TR_SUM  = IDX_W'(0);
    localparam logic [IDX_W-1:0] TR_CRCH = IDX_W'(1);
    localparam logic [IDX_W-1:0] TR_CRCL = IDX_W'(2);

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_SYNC  = 9'b0_0000_0010,
        ST_HDR   = 9'b0_0000_0100,
        ST_PAY   = 9'b0_0000_1000,
        ST_BSTUF = 9'b0_0001_0000,
        ST_SUM   = 9'b0_0010_0000,
        ST_CRCH  = 9'b0_0100_0000,
        ST_CRCL  = 9'b0_1000_0000,
        ST_TSTUF = 9'b1_0000_0000
    } t_state;

    // one byte from the sequencer to the output register
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       last;
    } t_emit;

    // crc-16/arc update by one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/sfb_seq.sv =====
// byte sequencer: frame state, checksum, crc and stuffing
`timescale 1ns / 1ps

module sfb_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [7:0]                      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_in_kind,
    input  logic [sfb_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                            i_take,
    output sfb_pkg::t_emit                  o_emit
);
    import sfb_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_bpay, n_bpay;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_bl, n_bl;
    logic             r_crc_on, n_crc_on;
    logic             r_in_frame, n_in_frame;
    logic [7:0]       r_stuff;
    logic [7:0]       r_ftype, n_ftype;
    logic [7:0]       r_pbyte, n_pbyte;

    logic             adv;
    logic             is_ff;
    logic [7:0]       cur_byte;
    logic [7:0]       hdr_byte;
    logic             cur_last;
    logic             do_after;
    logic             after_pay;
    logic             do_trail;
    logic [IDX_W-1:0] trail_sel;
    logic             acc;

    // header byte at the current index
    always_comb begin
        if (r_idx == IDX_W'(0)) begin
            hdr_byte = 8'(HDR_BYTES) + r_bl;
        end else if (r_idx == IDX_W'(1)) begin
            hdr_byte = r_crc_on ? CRC_FLAG : ZERO_BYTE;
        end else if (r_idx == IDX_W'(HDR_BYTES - 1)) begin
            hdr_byte = r_ftype;
        end else begin
            hdr_byte = ZERO_BYTE;
        end
    end

    // byte shown in the current state
    always_comb begin
        unique case (r_state)
            ST_SYNC:            cur_byte = SEP_VALUE;
            ST_HDR:             cur_byte = hdr_byte;
            ST_PAY:             cur_byte = r_pbyte;
            ST_BSTUF, ST_TSTUF: cur_byte = r_stuff;
            ST_SUM:             cur_byte = r_sum;
            ST_CRCH:            cur_byte = r_crc[15:8];
            ST_CRCL:            cur_byte = r_crc[7:0];
            default:            cur_byte = ZERO_BYTE;
        endcase
    end

    assign is_ff = (cur_byte == SEP_VALUE);
    assign adv   = (r_state != ST_IDLE) && i_take;

    // next state, accumulators and input acceptance
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_bpay     = r_bpay;
        n_sum      = r_sum;
        n_crc      = r_crc;
        n_bl       = r_bl;
        n_crc_on   = r_crc_on;
        n_in_frame = r_in_frame;
        n_ftype    = r_ftype;
        n_pbyte    = r_pbyte;
        cur_last   = 1'b0;
        do_after   = 1'b0;
        after_pay  = 1'b0;
        do_trail   = 1'b0;
        trail_sel  = TR_SUM;

        if (adv) begin
            unique case (r_state)
                ST_SYNC: begin
                    if (r_idx == IDX_W'(SYNC_BYTES - 1)) begin
                        n_state = ST_HDR;
                        n_idx   = IDX_W'(0);
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                ST_HDR, ST_PAY: begin
                    n_sum = r_sum + cur_byte;
                    if (r_crc_on) begin
                        n_crc = crc16_byte(r_crc, cur_byte);
                    end
                    if (r_state == ST_PAY) begin
                        n_bl = r_bl - 8'd1;
                    end
                    if (is_ff) begin
                        n_state = ST_BSTUF;
                        n_bpay  = (r_state == ST_PAY);
                    end else begin
                        do_after  = 1'b1;
                        after_pay = (r_state == ST_PAY);
                    end
                end
                ST_BSTUF: begin
                    n_sum     = r_sum + r_stuff;
                    do_after  = 1'b1;
                    after_pay = r_bpay;
                end
                ST_SUM, ST_CRCH, ST_CRCL: begin
                    if (r_state == ST_SUM) begin
                        trail_sel = TR_SUM;
                    end else if (r_state == ST_CRCH) begin
                        trail_sel = TR_CRCH;
                    end else begin
                        trail_sel = TR_CRCL;
                    end
                    if (is_ff) begin
                        n_state = ST_TSTUF;
                        n_idx   = trail_sel;
                    end else begin
                        do_trail = 1'b1;
                    end
                end
                ST_TSTUF: begin
                    do_trail  = 1'b1;
                    trail_sel = r_idx;
                end
                default: begin
                    n_state = r_state;
                end
            endcase

            // after a body byte and its stuff: next header byte, trailer or done
            if (do_after) begin
                if (!after_pay && (r_idx != IDX_W'(HDR_BYTES - 1))) begin
                    n_state = ST_HDR;
                    n_idx   = r_idx + IDX_W'(1);
                end else if (n_bl == 8'd0) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            // after a trailer byte and its stuff: next trailer byte or frame end
            if (do_trail) begin
                if ((trail_sel == TR_SUM) && r_crc_on) begin
                    n_state = ST_CRCH;
                end else if (trail_sel == TR_CRCH) begin
                    n_state = ST_CRCL;
                end else begin
                    n_state    = ST_IDLE;
                    n_in_frame = 1'b0;
                    cur_last   = 1'b1;
                end
            end
        end

        // a new word enters once the current one has shown its last byte
        o_in_ready = (r_state == ST_IDLE) || (adv && (n_state == ST_IDLE));
        acc        = i_in_valid && o_in_ready;

        if (acc) begin
            if (i_in_kind == KIND_START) begin
                n_state    = ST_SYNC;
                n_idx      = IDX_W'(0);
                n_sum      = 8'd0;
                n_crc      = 16'd0;
                n_crc_on   = i_in_data[CEN_BIT];
                n_bl       = i_in_data[PLEN_LSB +: 8];
                n_in_frame = 1'b1;
                n_ftype    = i_in_data[FTYPE_LSB +: 8];
            end else if (n_in_frame) begin
                n_state = ST_PAY;
                n_pbyte = i_in_data[PBYTE_LSB +: 8];
            end
        end
    end

    assign o_emit.vld  = adv;
    assign o_emit.data = cur_byte;
    assign o_emit.last = cur_last;

    // control and accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= IDX_W'(0);
            r_bpay     <= 1'b0;
            r_sum      <= 8'd0;
            r_crc      <= 16'd0;
            r_bl       <= 8'd0;
            r_crc_on   <= 1'b1;
            r_in_frame <= 1'b0;
            r_stuff    <= STUFF_RESET;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_bpay     <= n_bpay;
            r_sum      <= n_sum;
            r_crc      <= n_crc;
            r_bl       <= n_bl;
            r_crc_on   <= n_crc_on;
            r_in_frame <= n_in_frame;
            if (i_cfg_wr_en) begin
                r_stuff <= i_cfg_wr_data;
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        r_ftype <= n_ftype;
        r_pbyte <= n_pbyte;
    end

endmodule

// ===== rtl/sfb_oreg.sv =====
// output register holding one frame byte for the downstream side
`timescale 1ns / 1ps

module sfb_oreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfb_pkg::t_emit i_emit,
    output logic           o_take,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic           o_last
);
    import sfb_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    // room when empty or when the held word leaves this cycle
    assign o_take = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_emit.vld;
        end
    end

    // word payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_emit.vld) begin
            r_data <= i_emit.data;
            r_last <= i_emit.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// ===== rtl/serial_frame_builder_crc16_stuffing_unit.sv =====
// top level of the serial frame builder with checksum, crc-16 and byte stuffing
`timescale 1ns / 1ps

// Input words come in on the s_axis channel: tuser 0 opens a frame (type, length,
// crc enable in tdata), tuser 1 carries one payload byte. Encoded frame bytes leave
// on the m_axis channel, one byte per word, tlast on the final byte of a frame.
// The stuff byte is written through i_cfg_wr_en / i_cfg_wr_data, by the user only
// while idle; the block does not enforce it. The first byte of a word passes the
// sequencer state register and then the output register before m_axis. Throughput:
// the sequencer emits one byte per cycle while the output register takes it; a word
// yields 1 byte for a plain payload byte, 2 for a 0xFF byte, 10 to 12 for a start
// word, plus 1 to 6 trailer bytes on the last payload byte (up to 17 for a start word
// with zero length). The next word is taken in the cycle that the current word's
// last byte moves into the output register. Reset clears the frame state, selects
// crc on, sets the stuff byte to 0x55 and empties the output register. When the
// receiver stalls, the output word holds, the sequencer stops and s_axis tready
// drops once the word in work can no longer advance.

module serial_frame_builder_crc16_stuffing_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [7:0]                     i_cfg_wr_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // msg_type[7:0], payload_length[15:8], crc_enable[16], payload_byte[24:17], zero
    input  logic [sfb_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // kind[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]                     o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import sfb_pkg::*;

    t_emit emit;
    logic  take;

    // byte sequencer
    sfb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_in_kind     (i_s_axis_tuser),
        .i_in_data     (i_s_axis_tdata),
        .i_take        (take),
        .o_emit        (emit)
    );

    // output register
    sfb_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_take  (take),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/sfb_checker.sv =====
// port level checks for the frame builder, bound to the top level
`timescale 1ns / 1ps
`include "serial_frame_builder_crc16_stuffing_unit_assert.svh"

module sfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_wr_en,
    input logic [7:0] i_cfg_wr_data,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);
    import sfb_pkg::*;

    logic [7:0] r_stuff_seen;

    // stuff byte as last written on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuff_seen <= STUFF_RESET;
        end else if (i_cfg_wr_en) begin
            r_stuff_seen <= i_cfg_wr_data;
        end
    end

    // a stalled output word keeps its value
    `SFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "stalled output word changed")

    // a 0xff byte that is not the stuff byte never ends a frame
    `SFB_ASSERT_SAME(a_ff_not_last, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata == SEP_VALUE) && (r_stuff_seen != SEP_VALUE),
        !o_m_axis_tlast, "frame ended on an unstuffed 0xff")

    // reset leaves the output empty
    `SFB_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "output valid right after reset")

    // reset leaves the sequencer idle and ready for a word
    `SFB_ASSERT_NEXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, o_s_axis_tready, "input not ready right after reset")

endmodule

bind serial_frame_builder_crc16_stuffing_unit sfb_checker u_sfb_checker (.*);

// ===== sim/serial_frame_builder_crc16_stuffing_unit_tb.sv =====
// testbench for the serial frame builder: random stream traffic checked byte by byte
`timescale 1ns / 1ps

module serial_frame_builder_crc16_stuffing_unit_tb;
    import sfb_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;

    // one encoded byte as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    // frame encoder prediction and the queue of bytes still owed by the block
    class t_frame_scoreboard;
        t_enc_byte   pend_q[$];
        logic [7:0]  stuff_val;
        logic [7:0]  sum_acc;
        logic [15:0] crc_acc;
        logic [7:0]  left;
        bit          crc_sel;
        bit          open;
        int          errors;

        function new();
            stuff_val = STUFF_RESET;
            sum_acc   = 8'h00;
            crc_acc   = 16'h0000;
            left      = 8'h00;
            crc_sel   = 1'b1;
            open      = 1'b0;
            errors    = 0;
        endfunction

        // reflected crc-16, one bit per pass
        function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            bit          fb;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void add_raw(logic [7:0] b);
            pend_q.push_back({b, 1'b0});
        endfunction

        // header and payload bytes: summed, crc'd, stuff counted in the sum
        function void add_body(logic [7:0] b);
            add_raw(b);
            sum_acc = sum_acc + b;
            if (crc_sel) crc_acc = crc_next(crc_acc, b);
            if (b == SEP_VALUE) begin
                add_raw(stuff_val);
                sum_acc = sum_acc + stuff_val;
            end
        endfunction

        function void add_trailer(logic [7:0] b);
            add_raw(b);
            if (b == SEP_VALUE) add_raw(stuff_val);
        endfunction

        function void close_frame();
            t_enc_byte tail;
            add_trailer(sum_acc);
            if (crc_sel) begin
                add_trailer(crc_acc[15:8]);
                add_trailer(crc_acc[7:0]);
            end
            tail      = pend_q.pop_back();
            tail.last = 1'b1;
            pend_q.push_back(tail);
            open = 1'b0;
        endfunction

        // called for every input word the block accepted
        function void note_word(logic kind, logic [IN_TDATA_W-1:0] tdata);
            logic [7:0] ftype;
            logic [7:0] plen;
            logic [7:0] pbyte;
            logic       cen;
            ftype = tdata[FTYPE_LSB +: 8];
            plen  = tdata[PLEN_LSB +: 8];
            cen   = tdata[CEN_BIT];
            pbyte = tdata[PBYTE_LSB +: 8];
            if (kind == KIND_START) begin
                sum_acc = 8'h00;
                crc_acc = 16'h0000;
                crc_sel = cen;
                left    = plen;
                open    = 1'b1;
                for (int i = 0; i < SYNC_BYTES; i++) add_raw(SEP_VALUE);
                add_body(8'(HDR_BYTES) + plen);
                add_body(cen ? CRC_FLAG : ZERO_BYTE);
                for (int i = 0; i < HDR_BYTES - 3; i++) add_body(ZERO_BYTE);
                add_body(ftype);
                if (left == 8'h00) close_frame();
            end else if (open) begin
                add_body(pbyte);
                left = left - 8'h01;
                if (left == 8'h00) close_frame();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_byte(logic [7:0] d, logic l);
            t_enc_byte want;
            if (pend_q.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", d, l));
                return;
            end
            want = pend_q.pop_front();
            if (d !== want.data)
                report($sformatf("byte %02h, expected %02h", d, want.data));
            if (l !== want.last)
                report($sformatf("tlast %0b, expected %0b (byte %02h)", l, want.last, d));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_en = 1'b0;
    logic [7:0]            cfg_data = 8'h00;
    logic                  tx_valid = 1'b0;
    logic [IN_TDATA_W-1:0] tx_tdata = '0;
    logic                  tx_tuser = 1'b0;
    logic                  rx_ready = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    bit                    calm = 1'b0;
    bit                    squeeze = 1'b0;
    t_frame_scoreboard     sb;

    serial_frame_builder_crc16_stuffing_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (s_ready),
        // msg_type[7:0], payload_length[15:8], crc_enable[16], payload_byte[24:17], zero
        .i_s_axis_tdata  (tx_tdata),
        // kind[0]
        .i_s_axis_tuser  (tx_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (rx_ready),
        // out_byte[7:0]
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one word, return once it is taken
    task automatic send_word(logic kind, logic [IN_TDATA_W-1:0] tdata);
        int gap;
        gap = calm ? 0 : rand_gap();
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_tdata <= tdata;
        tx_tuser <= kind;
        do @(posedge clk); while (!s_ready);
        sb.note_word(kind, tdata);
    endtask

    // unused fields carry random values, the top seven bits stay zero
    task automatic send_start(logic [7:0] ftype, logic [7:0] plen, logic cen);
        send_word(KIND_START, {7'b0, 8'($urandom), cen, plen, ftype});
    endtask

    task automatic send_pay(logic [7:0] b);
        send_word(KIND_PAYLOAD, {7'b0, b, 1'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    // stuff byte register, only written while idle
    task automatic write_stuff(logic [7:0] v);
        cfg_data <= v;
        cfg_en   <= 1'b1;
        @(posedge clk);
        cfg_en   <= 1'b0;
        sb.stuff_val = v;
    endtask

    task automatic wait_drained();
        tx_valid <= 1'b0;
        while (sb.pend_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random frames, mostly complete, some abandoned, some stray payload words
    task automatic run_frames(int n_items);
        int         sent;
        int         r;
        int         cut;
        logic [7:0] len;
        logic [7:0] ftype;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            calm = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 19);
            if (r == 0 && !sb.open) begin
                send_pay(8'($urandom));
            end else begin
                r = $urandom_range(0, 19);
                if (r < 13) len = 8'($urandom_range(0, 6));
                else if (r < 18) len = 8'($urandom_range(7, 24));
                else if (r == 18) len = 8'd247;
                else len = 8'($urandom_range(248, 255));
                cut = int'(len);
                if (len > 24) cut = $urandom_range(0, 3);
                else if (len > 0 && $urandom_range(0, 14) == 0) cut = $urandom_range(0, len - 1);
                ftype = ($urandom_range(0, 7) == 0) ? SEP_VALUE : 8'($urandom);
                send_start(ftype, len, 1'($urandom));
                sent++;
                for (int i = 0; i < cut; i++) begin
                    b = ($urandom_range(0, 3) == 0) ? SEP_VALUE : 8'($urandom);
                    // steer the checksum to 0xff now and then so the trailer gets stuffed
                    if (i == len - 1 && $urandom_range(0, 3) == 0) b = SEP_VALUE - sb.sum_acc;
                    send_pay(b);
                    sent++;
                end
            end
        end
        // leave no frame open across a register write
        if (sb.open) send_start(8'($urandom), 8'h00, 1'($urandom));
        calm = 1'b0;
    endtask

    // receiver: random ready, one long hold on request
    initial begin
        int n;
        int g;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (squeeze) begin
                rx_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            rx_ready <= 1'b1;
            repeat (n) @(posedge clk);
            g = rand_gap();
            if (g > 0) begin
                rx_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // output byte monitor
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_valid && rx_ready) sb.check_byte(m_tdata, m_tlast);
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((tx_valid && s_ready) || (m_valid && rx_ready) || !rst_n) idle = 0;
            else idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin
        logic [7:0] b;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset stuff byte, edge lengths and types
        send_pay(SEP_VALUE);                 // payload with no frame open
        send_start(SEP_VALUE, 8'd0, 1'b1);   // empty payload, stuffed type
        send_start(ZERO_BYTE, 8'd0, 1'b0);
        send_start(8'h5A, 8'd3, 1'b1);
        send_pay(SEP_VALUE);
        send_pay(ZERO_BYTE);
        send_pay(8'hA5);
        send_start(8'h01, 8'd247, 1'b1);     // size byte 0xff, later abandoned
        send_pay(SEP_VALUE);
        send_start(8'hC3, 8'd255, 1'b0);     // size wraps, abandoned
        send_pay(8'h01);
        send_start(8'h7E, 8'd248, 1'b1);     // size wraps to zero
        send_start(8'h80, 8'd2, 1'b0);
        send_pay(SEP_VALUE);
        send_pay(SEP_VALUE);
        send_start(8'h33, 8'd1, 1'b0);
        b = SEP_VALUE - sb.sum_acc;          // checksum 0xff, frame ends on a stuff byte
        send_pay(b);
        send_pay(ZERO_BYTE);                 // after the frame closed
        wait_drained();

        write_stuff(8'hFF);
        run_frames(30);
        wait_drained();

        write_stuff(8'h00);
        squeeze = 1'b1;
        run_frames(30);
        wait_drained();

        write_stuff(8'($urandom));
        run_frames(30);
        wait_drained();

        write_stuff(8'($urandom));
        run_frames(25);
        wait_drained();
        repeat (30) @(posedge clk);

        if (sb.pend_q.size() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pend_q.size()));
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
